FILE: rtl/ownership_borrow_state_table_macros.svh
// Assertion macros for the ownership borrow state table.
// Included by the top level; uses no other file.
`ifndef OWNERSHIP_BORROW_STATE_TABLE_MACROS_SVH
`define OWNERSHIP_BORROW_STATE_TABLE_MACROS_SVH

// same-cycle implication, off during reset
`define OBST_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("obst assertion failed");

// next-cycle implication, active during reset
`define OBST_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("obst assertion failed");

`endif

FILE: rtl/obst_pkg.sv
// Package for the ownership borrow state table: sizes, codes and payload types.
// No dependencies.
`timescale 1ns / 1ps

package obst_pkg;

   localparam int NUM_SLOTS  = 256;
   localparam int MAX_SHARED = 255;
   localparam int SLOT_W     = $clog2(NUM_SLOTS);
   localparam int Q_DEPTH    = 2;
   localparam int QPTR_W     = $clog2(Q_DEPTH);
   localparam int QCNT_W     = $clog2(Q_DEPTH + 1);
   localparam logic [7:0] SHARED_CAP = 8'((MAX_SHARED < 255) ? MAX_SHARED : 255);

   typedef enum logic [3:0] {
      OP_DECLARE     = 4'd0,
      OP_INIT        = 4'd1,
      OP_READ        = 4'd2,
      OP_MOVE        = 4'd3,
      OP_ASSIGN      = 4'd4,
      OP_BORROW_SHR  = 4'd5,
      OP_RELEASE_SHR = 4'd6,
      OP_BORROW_MUT  = 4'd7,
      OP_RELEASE_MUT = 4'd8,
      OP_SNAPSHOT    = 4'd9,
      OP_INVALID     = 4'd10
   } op_type;

   typedef enum logic [2:0] {
      ST_UNINIT = 3'd0,
      ST_OWNED  = 3'd1,
      ST_SHARED = 3'd2,
      ST_MUT    = 3'd3,
      ST_MOVED  = 3'd4
   } own_type;

   typedef enum logic [2:0] {
      E_NONE       = 3'd0,
      E_UNDECLARED = 3'd1,
      E_DECLARED   = 3'd2,
      E_ILLEGAL    = 3'd3,
      E_UNINIT     = 3'd4,
      E_MOVED      = 3'd5,
      E_MUTREAD    = 3'd6,
      E_FULL       = 3'd7
   } err_type;

   typedef struct packed {
      logic [3:0] mode;
      logic [7:0] value_slot;
   } req_type;

   typedef struct packed {
      logic       ok;
      logic [2:0] error_code;
      logic [2:0] owner_state;
      logic [7:0] borrow_count;
      logic       is_declared;
   } rsp_type;

   typedef struct packed {
      op_type              op;
      logic                in_range;
      logic [SLOT_W-1:0]   addr;
   } item_type;

   typedef struct packed {
      logic [2:0] state;
      logic [7:0] count;
   } entry_type;

endpackage

FILE: rtl/obst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module obst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/obst_front.sv
// Front end: accepts request transactions, decodes the mode, range-checks the slot
// and queues the classified item for the back end. Depends on obst_pkg.
`timescale 1ns / 1ps

module obst_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  obst_pkg::req_type req_data,
   output logic              q_valid,
   output obst_pkg::item_type q_item,
   input  logic              q_take
);

   obst_pkg::item_type              ent_ff [obst_pkg::Q_DEPTH];
   logic [obst_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [obst_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [obst_pkg::QCNT_W-1:0]     cnt_ff, cnt_in;
   obst_pkg::item_type              cls;
   logic                            wr, rd;

   always_comb begin
      cls.in_range = 32'(req_data.value_slot) < obst_pkg::NUM_SLOTS;
      cls.addr     = obst_pkg::SLOT_W'(req_data.value_slot);
      if (req_data.mode > 4'(obst_pkg::OP_SNAPSHOT)) begin
         cls.op = obst_pkg::OP_INVALID;
      end else begin
         cls.op = obst_pkg::op_type'(req_data.mode);
      end
   end

   assign full    = cnt_ff == obst_pkg::QCNT_W'(obst_pkg::Q_DEPTH);
   assign q_valid = cnt_ff != '0;
   assign q_item  = ent_ff[rd_ptr_ff];
   assign wr      = push && !full;
   assign rd      = q_take && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr) begin
         wr_ptr_in = (wr_ptr_ff == obst_pkg::QPTR_W'(obst_pkg::Q_DEPTH - 1))
            ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd) begin
         rd_ptr_in = (rd_ptr_ff == obst_pkg::QPTR_W'(obst_pkg::Q_DEPTH - 1))
            ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff;
      if (wr && !rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (rd && !wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (wr) begin
         ent_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

FILE: rtl/obst_back.sv
// Back end: reads the slot entry, checks the operation, writes the slot back
// and holds the response register. Depends on obst_pkg and obst_ram.
`timescale 1ns / 1ps

module obst_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  obst_pkg::item_type q_item,
   output logic               q_take,
   output logic               empty,
   input  logic               pop,
   output obst_pkg::rsp_type  rsp_data
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type                        state_ff, state_in;
   obst_pkg::item_type               item_ff, item_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   obst_pkg::rsp_type                rsp_ff, rsp_in;
   logic [obst_pkg::NUM_SLOTS-1:0]   declared_ff, declared_in;

   obst_pkg::entry_type  rd_ent, wr_ent;
   logic                 wr_en;
   logic                 decl, new_decl, ok;
   logic [2:0]           cur_st, new_st;
   logic [7:0]           cur_cnt, new_cnt;
   obst_pkg::err_type    err;
   obst_pkg::rsp_type    result;

   obst_ram #(
      .WIDTH ($bits(obst_pkg::entry_type)),
      .DEPTH (obst_pkg::NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (item_ff.addr),
      .wr_data (wr_ent),
      .rd_en   (q_take),
      .rd_addr (q_item.addr),
      .rd_data (rd_ent)
   );

   always_comb begin
      decl     = item_ff.in_range && declared_ff[item_ff.addr];
      cur_st   = decl ? rd_ent.state : obst_pkg::ST_UNINIT;
      cur_cnt  = decl ? rd_ent.count : 8'd0;
      new_st   = cur_st;
      new_cnt  = cur_cnt;
      new_decl = decl;
      err      = obst_pkg::E_NONE;
      if (!item_ff.in_range) begin
         err = obst_pkg::E_UNDECLARED;
      end else if (item_ff.op == obst_pkg::OP_INVALID) begin
         err = decl ? obst_pkg::E_ILLEGAL : obst_pkg::E_UNDECLARED;
      end else if (item_ff.op == obst_pkg::OP_DECLARE) begin
         if (decl) begin
            err = obst_pkg::E_DECLARED;
         end else begin
            new_decl = 1'b1;
            new_st   = obst_pkg::ST_UNINIT;
            new_cnt  = 8'd0;
         end
      end else if (!decl) begin
         err = obst_pkg::E_UNDECLARED;
      end else begin
         unique case (item_ff.op)
            obst_pkg::OP_INIT: begin
               if (cur_st == obst_pkg::ST_UNINIT || cur_st == obst_pkg::ST_MOVED) begin
                  new_st  = obst_pkg::ST_OWNED;
                  new_cnt = 8'd0;
               end else begin
                  err = obst_pkg::E_ILLEGAL;
               end
            end
            obst_pkg::OP_READ: begin
               if (cur_st == obst_pkg::ST_UNINIT) begin
                  err = obst_pkg::E_UNINIT;
               end else if (cur_st == obst_pkg::ST_MOVED) begin
                  err = obst_pkg::E_MOVED;
               end else if (cur_st == obst_pkg::ST_MUT) begin
                  err = obst_pkg::E_MUTREAD;
               end else if (cur_st > obst_pkg::ST_MOVED) begin
                  err = obst_pkg::E_ILLEGAL;
               end
            end
            obst_pkg::OP_MOVE: begin
               if (cur_st == obst_pkg::ST_OWNED) begin
                  new_st = obst_pkg::ST_MOVED;
               end else begin
                  err = obst_pkg::E_ILLEGAL;
               end
            end
            obst_pkg::OP_ASSIGN: begin
               if (cur_st == obst_pkg::ST_SHARED || cur_st == obst_pkg::ST_MUT ||
                   cur_st > obst_pkg::ST_MOVED) begin
                  err = obst_pkg::E_ILLEGAL;
               end else begin
                  new_st  = obst_pkg::ST_OWNED;
                  new_cnt = 8'd0;
               end
            end
            obst_pkg::OP_BORROW_SHR: begin
               if (cur_st != obst_pkg::ST_OWNED && cur_st != obst_pkg::ST_SHARED) begin
                  err = obst_pkg::E_ILLEGAL;
               end else if (cur_cnt >= obst_pkg::SHARED_CAP) begin
                  err = obst_pkg::E_FULL;
               end else begin
                  new_st  = obst_pkg::ST_SHARED;
                  new_cnt = cur_cnt + 8'd1;
               end
            end
            obst_pkg::OP_RELEASE_SHR: begin
               if (cur_st != obst_pkg::ST_SHARED || cur_cnt == 8'd0) begin
                  err = obst_pkg::E_ILLEGAL;
               end else begin
                  new_cnt = cur_cnt - 8'd1;
                  if (cur_cnt == 8'd1) begin
                     new_st = obst_pkg::ST_OWNED;
                  end
               end
            end
            obst_pkg::OP_BORROW_MUT: begin
               if (cur_st == obst_pkg::ST_OWNED) begin
                  new_st = obst_pkg::ST_MUT;
               end else begin
                  err = obst_pkg::E_ILLEGAL;
               end
            end
            obst_pkg::OP_RELEASE_MUT: begin
               if (cur_st == obst_pkg::ST_MUT) begin
                  new_st = obst_pkg::ST_OWNED;
               end else begin
                  err = obst_pkg::E_ILLEGAL;
               end
            end
            default: begin
            end
         endcase
      end
      ok                  = err == obst_pkg::E_NONE;
      result.ok           = ok;
      result.error_code   = err;
      result.owner_state  = ok ? new_st : cur_st;
      result.borrow_count = ok ? new_cnt : cur_cnt;
      result.is_declared  = ok ? new_decl : decl;
      wr_ent.state        = new_st;
      wr_ent.count        = new_cnt;
   end

   assign wr_en    = (state_ff == S_EXEC) && ok;
   assign q_take   = (state_ff == S_IDLE) && q_valid && (!rsp_valid_ff || pop);
   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      declared_in  = declared_ff;
      if (pop) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (q_take) begin
               item_in  = q_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_valid_in = 1'b1;
            rsp_in       = result;
            state_in     = S_IDLE;
            if (ok && item_ff.op == obst_pkg::OP_DECLARE) begin
               declared_in[item_ff.addr] = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         declared_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         declared_ff  <= declared_in;
      end
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

endmodule

FILE: rtl/ownership_borrow_state_table.sv
// Top level of the ownership borrow state table: front queue, back end, assertions.
// Depends on obst_pkg, obst_front, obst_back and the assertion macro header.
//
//   channel    ports                          direction   handshake
//   request    push, full, req_data           in          push && !full
//   response   empty, pop, rsp_data           out         pop && !empty
//
// In the back end, each transaction first gets the registered slot RAM read (S_IDLE),
// then the check, write-back and response load (S_EXEC); a new transaction is taken
// only once the last is done. A 2-entry queue lets requests land while the back end
// waits on a full response register. Reset clears the declared flags, so no
// clearing pass is needed. The back end stalls while a response waits unpopped.
`timescale 1ns / 1ps
`include "ownership_borrow_state_table_macros.svh"

module ownership_borrow_state_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  obst_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output obst_pkg::rsp_type rsp_data
);

   logic               q_valid;
   logic               q_take;
   obst_pkg::item_type q_item;

   obst_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_take   (q_take)
   );

   obst_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_take   (q_take),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   `OBST_ASSERT_IMPLIES(a_ok_no_error, clock, reset, !empty,
      rsp_data.ok == (rsp_data.error_code == obst_pkg::E_NONE))
   `OBST_ASSERT_IMPLIES(a_ok_declared, clock, reset, !empty && rsp_data.ok,
      rsp_data.is_declared)
   `OBST_ASSERT_IMPLIES(a_shared_count, clock, reset, !empty && rsp_data.is_declared,
      (rsp_data.owner_state == obst_pkg::ST_SHARED) == (rsp_data.borrow_count != 8'd0))
   `OBST_ASSERT_NEXT(a_reset_clear, clock, reset, empty && !full)

endmodule
